### rtl/ddet_pkg.sv
// Shared types and constants for the deadlock detector.
// No dependencies; ddet_alu and the top level import it.
package ddet_pkg;

    typedef enum logic [2:0] {
        FUNC_LOAD_EXIST = 3'd0,
        FUNC_LOAD_AVAIL = 3'd1,
        FUNC_LOAD_ALLOC = 3'd2,
        FUNC_LOAD_REQ   = 3'd3,
        FUNC_RUN        = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_EQ  = 2'd1,
        ALU_LE  = 2'd2
    } t_alu_op;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_CMP   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_ADD   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    localparam logic REG_NUM_PROC = 1'b0;
    localparam logic REG_NUM_RES  = 1'b1;

    localparam logic [4:0] NUM_PROC_RESET = 5'd16;
    localparam logic [3:0] NUM_RES_RESET  = 4'd8;

endpackage

### rtl/ddet_ram.sv
// Single-port-write, single-port-read matrix memory with registered read data.
// Depends on nothing; instantiated twice by deadlock_detector_top.
module ddet_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ddet_alu.sv
// Shared adder and comparator for the check, compare, scan and add states.
// Depends on ddet_pkg for the operation codes.
module ddet_alu #(
    parameter int W = 21
) (
    input  ddet_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_y,
    output logic              o_flag
);
    import ddet_pkg::*;

    assign o_y = i_a + i_b;

    always_comb begin
        unique case (i_op)
            ALU_EQ:  o_flag = (i_a == i_b);
            ALU_LE:  o_flag = (i_a <= i_b);
            default: o_flag = 1'b0;
        endcase
    end

endmodule

### rtl/deadlock_detector_top.sv
// Top level of the multi-instance deadlock detector: sequencer, vectors and config.
// Depends on ddet_pkg, ddet_ram and ddet_alu.
//
// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              i_func, i_process_index,
//                                                 i_resource_index, i_value
// result    out        o_valid (one cycle)        o_process_index_res, o_deadlocked,
//                                                 o_status, o_last
// config    in/out     psel & penable & pwrite    paddr, pwdata, prdata, pready
//
// A load beat leaves busy low, so the next beat may follow at once.
// A run checks each resource column, then makes passes over the processes until a
// pass finishes none, then emits one result per process, using one shared
// adder/comparator and one matrix read per cycle. An error run ends after the check.
// Reset is synchronous; it sets the process and resource counts to 16 and 8.
// Results are one-cycle strobes; the receiver cannot stall them.
module deadlock_detector_top #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_process_index,
    input  logic [2:0]  i_resource_index,
    input  logic [15:0] i_value,
    output logic        o_valid,
    output logic [3:0]  o_process_index_res,
    output logic        o_deadlocked,
    output logic        o_status,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ddet_pkg::*;

    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CW    = COUNT_WIDTH;
    localparam int SW    = COUNT_WIDTH + $clog2(MAX_PROCESSES + 1);

    t_state r_state, n_state;
    logic            r_err;
    logic            n_err;
    logic [PW-1:0]   r_p, n_p;
    logic [RW-1:0]   r_r, n_r;
    logic [SW-1:0]   r_acc, n_acc;
    logic            r_progress, n_progress;
    logic [4:0]      r_num_proc;
    logic [3:0]      r_num_res;

    logic [CW-1:0]   r_exist [MAX_RESOURCES];
    logic [CW-1:0]   r_avail [MAX_RESOURCES];
    logic [CW-1:0]   r_work  [MAX_RESOURCES];
    logic            r_fin   [MAX_PROCESSES];

    logic            accept;
    logic            cfg_we;
    logic            res_ok;
    logic            proc_ok;
    logic            work_we;
    logic            work_init;
    logic            fin_set;
    logic            fin_clear;
    logic            adv;
    logic            adv_prog;
    logic [31:0]     np_sat;
    logic [31:0]     nr_sat;
    logic [PW-1:0]   p_last;
    logic [RW-1:0]   r_last;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [CW-1:0]   alloc_rd;
    logic [CW-1:0]   req_rd;
    t_alu_op         alu_op;
    logic [SW-1:0]   alu_a;
    logic [SW-1:0]   alu_b;
    logic [SW-1:0]   alu_y;
    logic            alu_flag;

    assign accept  = start && !busy;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign res_ok  = 32'(i_resource_index) < 32'(MAX_RESOURCES);
    assign proc_ok = 32'(i_process_index) < 32'(MAX_PROCESSES);
    assign prdata  = (paddr[2] == REG_NUM_RES) ? {28'd0, r_num_res} : {27'd0, r_num_proc};

    always_comb begin
        if (r_num_proc == 5'd0) begin
            np_sat = 32'd1;
        end else if (32'(r_num_proc) > 32'(MAX_PROCESSES)) begin
            np_sat = 32'(MAX_PROCESSES);
        end else begin
            np_sat = 32'(r_num_proc);
        end
        if (r_num_res == 4'd0) begin
            nr_sat = 32'd1;
        end else if (32'(r_num_res) > 32'(MAX_RESOURCES)) begin
            nr_sat = 32'(MAX_RESOURCES);
        end else begin
            nr_sat = 32'(r_num_res);
        end
    end

    assign p_last = PW'(np_sat - 32'd1);
    assign r_last = RW'(nr_sat - 32'd1);
    assign waddr  = AW'(32'(i_process_index) * 32'(MAX_RESOURCES) + 32'(i_resource_index));
    assign raddr  = AW'(32'(n_p) * 32'(MAX_RESOURCES) + 32'(n_r));

    ddet_ram #(
        .DEPTH (DEPTH),
        .WIDTH (CW)
    ) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (accept && i_func == FUNC_LOAD_ALLOC && res_ok && proc_ok),
        .i_waddr (waddr),
        .i_wdata (CW'(i_value)),
        .i_raddr (raddr),
        .o_rdata (alloc_rd)
    );

    ddet_ram #(
        .DEPTH (DEPTH),
        .WIDTH (CW)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (accept && i_func == FUNC_LOAD_REQ && res_ok && proc_ok),
        .i_waddr (waddr),
        .i_wdata (CW'(i_value)),
        .i_raddr (raddr),
        .o_rdata (req_rd)
    );

    ddet_alu #(
        .W (SW)
    ) u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_y    (alu_y),
        .o_flag (alu_flag)
    );

    always_comb begin
        n_state    = r_state;
        n_err      = 1'b0;
        n_p        = r_p;
        n_r        = r_r;
        n_acc      = r_acc;
        n_progress = r_progress;
        work_we    = 1'b0;
        work_init  = 1'b0;
        fin_set    = 1'b0;
        fin_clear  = 1'b0;
        adv        = 1'b0;
        adv_prog   = r_progress;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        unique case (r_state)
            S_IDLE: begin
                n_p = '0;
                n_r = '0;
                if (r_err) begin
                    n_err = 1'b0;
                end else if (accept && i_func == FUNC_RUN) begin
                    n_state   = S_CHECK;
                    fin_clear = 1'b1;
                end
            end
            S_CHECK: begin
                alu_op = ALU_ADD;
                alu_a  = (r_p == '0) ? SW'(r_avail[r_r]) : r_acc;
                alu_b  = SW'(alloc_rd);
                n_acc  = alu_y;
                if (r_p == p_last) begin
                    n_state = S_CMP;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            S_CMP: begin
                alu_op = ALU_EQ;
                alu_a  = r_acc;
                alu_b  = SW'(r_exist[r_r]);
                n_p    = '0;
                if (!alu_flag) begin
                    n_state = S_IDLE;
                    n_err   = 1'b1;
                    n_r     = '0;
                end else if (r_r == r_last) begin
                    work_init  = 1'b1;
                    n_state    = S_SCAN;
                    n_r        = '0;
                    n_progress = 1'b0;
                end else begin
                    n_state = S_CHECK;
                    n_r     = r_r + 1'b1;
                end
            end
            S_SCAN: begin
                alu_op = ALU_LE;
                alu_a  = SW'(req_rd);
                alu_b  = SW'(r_work[r_r]);
                if (r_fin[r_p] || !alu_flag) begin
                    adv = 1'b1;
                end else if (r_r == r_last) begin
                    n_state = S_ADD;
                    n_r     = '0;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_ADD: begin
                alu_op  = ALU_ADD;
                alu_a   = SW'(r_work[r_r]);
                alu_b   = SW'(alloc_rd);
                work_we = 1'b1;
                if (r_r == r_last) begin
                    fin_set  = 1'b1;
                    adv      = 1'b1;
                    adv_prog = 1'b1;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_EMIT: begin
                if (r_p == p_last) begin
                    n_state = S_IDLE;
                    n_p     = '0;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (adv) begin
            n_r = '0;
            if (r_p == p_last) begin
                n_p        = '0;
                n_progress = 1'b0;
                n_state    = adv_prog ? S_SCAN : S_EMIT;
            end else begin
                n_p        = r_p + 1'b1;
                n_progress = adv_prog;
                n_state    = S_SCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_err      <= 1'b0;
            r_p        <= '0;
            r_r        <= '0;
            r_progress <= 1'b0;
            r_num_proc <= NUM_PROC_RESET;
            r_num_res  <= NUM_RES_RESET;
        end else begin
            r_state    <= n_state;
            r_err      <= n_err;
            r_p        <= n_p;
            r_r        <= n_r;
            r_progress <= n_progress;
            if (cfg_we) begin
                if (paddr[2] == REG_NUM_PROC) begin
                    r_num_proc <= pwdata[4:0];
                end else begin
                    r_num_res <= pwdata[3:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_ok && i_func == FUNC_LOAD_EXIST) begin
            r_exist[RW'(i_resource_index)] <= CW'(i_value);
        end
        if (accept && res_ok && i_func == FUNC_LOAD_AVAIL) begin
            r_avail[RW'(i_resource_index)] <= CW'(i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_init) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_work[i] <= r_avail[i];
            end
        end else if (work_we) begin
            r_work[r_r] <= CW'(alu_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin_clear) begin
            for (int i = 0; i < MAX_PROCESSES; i++) begin
                r_fin[i] <= 1'b0;
            end
        end else if (fin_set) begin
            r_fin[r_p] <= 1'b1;
        end
    end

    // The error beat is issued from idle in the cycle after the failed check.
    assign busy                = (r_state != S_IDLE) || r_err;
    assign o_valid             = (r_state == S_EMIT) || r_err;
    assign o_status            = r_err;
    assign o_deadlocked        = (r_state == S_EMIT) && !r_fin[r_p];
    assign o_process_index_res = (r_state == S_EMIT) ? 4'(r_p) : 4'd0;
    assign o_last              = r_err || ((r_state == S_EMIT) && (r_p == p_last));

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside a run");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !busy)
        else $error("run continues after its last beat");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && !o_deadlocked && o_process_index_res == 4'd0)
        else $error("malformed error beat");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == FUNC_RUN |=> busy && !o_valid)
        else $error("accepted run did not start");

endmodule

### sim/deadlock_detector_top_test.sv
// Self-checking testbench for deadlock_detector_top: loads the resource vectors and
// matrices, runs detection and checks every result beat against a built-in predictor.
// Depends on ddet_pkg and the RTL under rtl/.
module deadlock_detector_top_test;
    import ddet_pkg::*;

    localparam int MAXP = 16;
    localparam int MAXR = 8;
    localparam int LIMIT = 4000000;
    localparam logic [2:0] FUNC_NONE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_NONE_LAST  = 3'd7;

    typedef struct packed {
        logic [3:0] proc;
        logic       deadlocked;
        logic       status;
        logic       last;
    } report_t;

    class deadlock_scoreboard;
        logic [15:0] exist_cnt [MAXR];
        logic [15:0] avail_cnt [MAXR];
        logic [15:0] alloc_cnt [MAXP][MAXR];
        logic [15:0] req_cnt [MAXP][MAXR];
        bit exist_set [MAXR];
        bit avail_set [MAXR];
        bit alloc_set [MAXP][MAXR];
        bit req_set [MAXP][MAXR];
        logic [4:0] proc_reg;
        logic [3:0] res_reg;
        report_t pending_reports [$];
        int mismatches;

        function new();
            proc_reg = NUM_PROC_RESET;
            res_reg = NUM_RES_RESET;
            mismatches = 0;
        endfunction

        function int procs_in_use();
            if (proc_reg == 0) return 1;
            if (proc_reg > MAXP) return MAXP;
            return int'(proc_reg);
        endfunction

        function int res_in_use();
            if (res_reg == 0) return 1;
            if (res_reg > MAXR) return MAXR;
            return int'(res_reg);
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == REG_NUM_PROC) proc_reg = data[4:0];
            else res_reg = data[3:0];
        endfunction

        function void predict_run();
            int np, nr, p, r;
            logic [31:0] col_sum;
            logic [31:0] work [MAXR];
            bit finished [MAXP];
            bit all_done, progress, fits;
            np = procs_in_use();
            nr = res_in_use();
            for (r = 0; r < nr; r++) begin
                col_sum = avail_cnt[r];
                for (p = 0; p < np; p++) col_sum += alloc_cnt[p][r];
                if (col_sum != exist_cnt[r]) begin
                    pending_reports.push_back('{4'd0, 1'b0, 1'b1, 1'b1});
                    return;
                end
            end
            for (r = 0; r < nr; r++) work[r] = avail_cnt[r];
            for (p = 0; p < MAXP; p++) finished[p] = 1'b0;
            all_done = 1'b0;
            progress = 1'b1;
            while (!all_done && progress) begin
                all_done = 1'b1;
                progress = 1'b0;
                for (p = 0; p < np; p++) begin
                    if (!finished[p]) begin
                        all_done = 1'b0;
                        fits = 1'b1;
                        for (r = 0; r < nr; r++)
                            if (req_cnt[p][r] > work[r]) fits = 1'b0;
                        if (fits) begin
                            for (r = 0; r < nr; r++) work[r] += alloc_cnt[p][r];
                            finished[p] = 1'b1;
                            progress = 1'b1;
                        end
                    end
                end
            end
            for (p = 0; p < np; p++)
                pending_reports.push_back('{4'(p), !finished[p], 1'b0, p == np - 1});
        endfunction

        function void note_command(logic [2:0] f, logic [3:0] pi, logic [2:0] ri,
                                   logic [15:0] v);
            case (f)
                FUNC_LOAD_EXIST: begin
                    exist_cnt[ri] = v;
                    exist_set[ri] = 1'b1;
                end
                FUNC_LOAD_AVAIL: begin
                    avail_cnt[ri] = v;
                    avail_set[ri] = 1'b1;
                end
                FUNC_LOAD_ALLOC: begin
                    alloc_cnt[pi][ri] = v;
                    alloc_set[pi][ri] = 1'b1;
                end
                FUNC_LOAD_REQ: begin
                    req_cnt[pi][ri] = v;
                    req_set[pi][ri] = 1'b1;
                end
                FUNC_RUN: predict_run();
                default: ;
            endcase
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: proc %0d dl %0b st %0b last %0b",
                             got.proc, got.deadlocked, got.status, got.last);
                return;
            end
            want = pending_reports.pop_front();
            if (got.proc !== want.proc || got.deadlocked !== want.deadlocked ||
                    got.status !== want.status || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected proc %0d dl %0b st %0b last %0b,",
                             want.proc, want.deadlocked, want.status, want.last,
                             " got proc %0d dl %0b st %0b last %0b",
                             got.proc, got.deadlocked, got.status, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [3:0]  i_process_index = '0;
    logic [2:0]  i_resource_index = '0;
    logic [15:0] i_value = '0;
    logic        o_valid;
    logic [3:0]  o_process_index_res;
    logic        o_deadlocked;
    logic        o_status;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    deadlock_scoreboard sb = new();
    int cycle_count = 0;
    int idle_pct = 0;
    int items_sent = 0;

    deadlock_detector_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_process_index    (i_process_index),
        .i_resource_index   (i_resource_index),
        .i_value            (i_value),
        .o_valid            (o_valid),
        .o_process_index_res(o_process_index_res),
        .o_deadlocked       (o_deadlocked),
        .o_status           (o_status),
        .o_last             (o_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_report('{o_process_index_res, o_deadlocked, o_status, o_last});
    end

    // Start stays high between accepted beats unless an idle gap or settle() drops it.
    task automatic send_command(input logic [2:0] f, input logic [3:0] pi,
                                input logic [2:0] ri, input logic [15:0] v);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_process_index <= pi;
        i_resource_index <= ri;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        sb.note_command(f, pi, ri, v);
        if (f <= FUNC_RUN) items_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_reports.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic random_sequence();
        int np, nr, p, r, mode, top, flip;
        logic [31:0] col_sum;
        np = sb.procs_in_use();
        nr = sb.res_in_use();
        mode = $urandom_range(99);
        top = ($urandom_range(4) == 0) ? 65535 / (np + 1) : 3;
        if (mode < 12) begin
            repeat ($urandom_range(1, 6))
                send_command(3'($urandom_range(int'(FUNC_LOAD_REQ))), 4'($urandom),
                             3'($urandom), 16'($urandom));
        end else begin
            for (p = 0; p < np; p++) begin
                for (r = 0; r < nr; r++) begin
                    if (!sb.alloc_set[p][r] || sb.alloc_cnt[p][r] > top ||
                            $urandom_range(np * nr) < 3)
                        send_command(FUNC_LOAD_ALLOC, 4'(p), 3'(r), 16'($urandom_range(top)));
                    if (!sb.req_set[p][r] || $urandom_range(np * nr) < 3)
                        send_command(FUNC_LOAD_REQ, 4'(p), 3'(r),
                                     16'($urandom_range(top + 1)));
                end
            end
            for (r = 0; r < nr; r++)
                if (!sb.avail_set[r] || sb.avail_cnt[r] > top || $urandom_range(nr) < 2)
                    send_command(FUNC_LOAD_AVAIL, 4'($urandom), 3'(r),
                                 16'($urandom_range(top)));
            for (r = 0; r < nr; r++) begin
                col_sum = sb.avail_cnt[r];
                for (p = 0; p < np; p++) col_sum += sb.alloc_cnt[p][r];
                if (!sb.exist_set[r] || sb.exist_cnt[r] != col_sum[15:0])
                    send_command(FUNC_LOAD_EXIST, 4'($urandom), 3'(r), col_sum[15:0]);
            end
            if (mode < 30) begin
                flip = $urandom_range(nr - 1);
                send_command(FUNC_LOAD_EXIST, 4'($urandom), 3'(flip),
                             sb.exist_cnt[flip] ^ (16'd1 << $urandom_range(15)));
            end
        end
        if ($urandom_range(3) == 0)
            send_command(3'($urandom_range(FUNC_NONE_FIRST, FUNC_NONE_LAST)), 4'($urandom),
                         3'($urandom), 16'($urandom));
        for (r = 0; r < nr; r++) begin
            if (!sb.exist_set[r])
                send_command(FUNC_LOAD_EXIST, 4'($urandom), 3'(r), 16'($urandom_range(7)));
            if (!sb.avail_set[r])
                send_command(FUNC_LOAD_AVAIL, 4'($urandom), 3'(r), 16'($urandom_range(3)));
            for (p = 0; p < np; p++) begin
                if (!sb.alloc_set[p][r])
                    send_command(FUNC_LOAD_ALLOC, 4'(p), 3'(r), 16'($urandom_range(3)));
                if (!sb.req_set[p][r])
                    send_command(FUNC_LOAD_REQ, 4'(p), 3'(r), 16'($urandom_range(3)));
            end
        end
        send_command(FUNC_RUN, 4'($urandom), 3'($urandom), 16'($urandom));
    endtask

    initial begin
        int ph;
        int phase_start;
        logic [4:0] proc_val;
        logic [3:0] res_val;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();
        write_reg(REG_NUM_PROC, 32'd1);
        write_reg(REG_NUM_RES, 32'd1);

        // One process and one resource: full-scale counts, a blocked request, an
        // overflowing column that must not wrap, and ignored beats.
        send_command(FUNC_LOAD_EXIST, 4'd0, 3'd0, 16'hFFFF);
        send_command(FUNC_LOAD_AVAIL, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_LOAD_ALLOC, 4'd0, 3'd0, 16'hFFFF);
        send_command(FUNC_LOAD_REQ, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_RUN, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_LOAD_REQ, 4'd0, 3'd0, 16'h0001);
        send_command(FUNC_RUN, 4'hF, 3'd7, 16'hFFFF);
        send_command(FUNC_LOAD_AVAIL, 4'hF, 3'd0, 16'hFFFF);
        send_command(FUNC_RUN, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_NONE_FIRST, 4'hF, 3'd7, 16'hFFFF);
        send_command(FUNC_NONE_LAST, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_LOAD_ALLOC, 4'hF, 3'd7, 16'hAAAA);
        send_command(FUNC_LOAD_REQ, 4'hF, 3'd7, 16'h5555);
        send_command(FUNC_LOAD_AVAIL, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_RUN, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_LOAD_REQ, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_RUN, 4'd0, 3'd0, 16'h0000);
        send_command(FUNC_RUN, 4'd0, 3'd0, 16'h0000);

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin proc_val = 5'd31; res_val = 4'd15; idle_pct = 0; end
                1: begin proc_val = 5'd0; res_val = 4'd0; idle_pct = 57; end
                2: begin
                    proc_val = 5'($urandom_range(2, 6));
                    res_val = 4'($urandom_range(1, 4));
                    idle_pct = 0;
                end
                3: begin proc_val = 5'd16; res_val = 4'd8; idle_pct = 30; end
                4: begin
                    proc_val = 5'($urandom_range(1, 16));
                    res_val = 4'($urandom_range(1, 8));
                    idle_pct = 57;
                end
                default: begin proc_val = 5'd3; res_val = 4'd2; idle_pct = 30; end
            endcase
            settle();
            write_reg(REG_NUM_PROC, {27'($urandom), proc_val});
            write_reg(REG_NUM_RES, {28'($urandom), res_val});
            phase_start = items_sent;
            do random_sequence();
            while (items_sent - phase_start < 12 || items_sent < 58 * (ph + 1));
        end

        start <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
